>>> rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types and constants shared by the serial line editor and its interfaces.
// ----------------------------------------------------------------------------
package sle_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RK_ECHO    = 2'd0,
    RK_DONE    = 2'd1,
    RK_TIMEOUT = 2'd2,
    RK_READ    = 2'd3
  } kind_e;

  // Pending work handed to the result sequencer
  typedef enum logic [1:0] {
    EV_LINE    = 2'd0,
    EV_ERASE   = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_READ    = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    STEP_FIRST  = 2'd0,
    STEP_SECOND = 2'd1,
    STEP_THIRD  = 2'd2,
    STEP_SPARE  = 2'd3
  } step_e;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChEsc   = 8'd27;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQ     = 8'h71;

  localparam logic [15:0] MaxWaitReset = 16'd1000;
  localparam logic [15:0] IdleMax      = 16'hFFFF;
  localparam int unsigned StoreDepth   = 256;

  // APB register index
  localparam logic RegMaxWait = 1'b0;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] in_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [7:0] line_length;
    logic       quit;
    logic       last;
  } out_t;

  typedef struct packed {
    ev_e        kind;
    logic [7:0] len;
    logic       quit;
  } ev_t;

endpackage

>>> rtl/sle_if.sv
// ----------------------------------------------------------------------------
// sle_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface sle_in_if;
  logic          valid;
  logic          ready;
  sle_pkg::in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sle_out_if;
  logic          valid;
  logic          ready;
  sle_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/serial_line_editor.sv
// ----------------------------------------------------------------------------
// serial_line_editor
// Builds a text line from received bytes with backspace editing, echo,
// idle timeout and readback of stored characters.
// ----------------------------------------------------------------------------
// An input transaction is accepted every cycle as long as the result side
// keeps up. Items that give no result (stored characters, escape, idle ticks
// without timeout) wait only while one item's results are still leaving and
// a later item's results are already queued behind them. Results leave one
// per cycle while the output is ready: a backspace on a non-empty line gives
// three, a line end two, a timeout or readback one, so the output port sets
// the sustained rate.
// Characters live in a 256 x 8 synchronous memory; readback data is taken
// from its registered read port when the read passes to the result sequencer. The memory has
// no reset and no clearing pass: reading a never-written entry returns
// undefined data.
module serial_line_editor #(
  parameter int unsigned MAX_LEN = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sle_in_if.sink             in_if,
  sle_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [7:0] LenLimit = (MAX_LEN < 255) ? 8'(MAX_LEN) : 8'd255;

  logic [7:0]  store_mem [sle_pkg::StoreDepth];
  logic [7:0]  rd_q;

  logic [15:0] max_wait_q;
  logic [7:0]  cur_len_q, cur_len_d;
  logic [15:0] idle_q, idle_d;
  logic        first_q_q, first_q_d;

  logic        ev_valid_q, ev_valid_d;
  sle_pkg::ev_t ev_q, new_ev;
  logic        new_ev_valid;

  logic        em_valid_q, em_valid_d;
  sle_pkg::ev_t em_q, em_d;
  logic [7:0]  em_byte_q, em_byte_d;
  sle_pkg::step_e em_step_q, em_step_d;
  logic        em_last;
  logic        em_done;
  logic        ev_take;

  logic        in_ready;
  logic        in_fire;
  logic        wr_en;
  logic [7:0]  wr_data;
  logic [15:0] idle_inc;
  sle_pkg::op_e op;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sle_pkg::RegMaxWait) ? {16'd0, max_wait_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wait_q <= sle_pkg::MaxWaitReset;
    end else if (psel && penable && pwrite && paddr[2] == sle_pkg::RegMaxWait) begin
      max_wait_q <= pwdata[15:0];
    end
  end

  // Handshake
  assign em_done     = em_valid_q && out_if.ready && em_last;
  assign ev_take     = ev_valid_q && (!em_valid_q || em_done);
  assign in_ready    = !ev_valid_q || ev_take;
  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;
  assign op          = sle_pkg::op_e'(in_if.payload.operation);
  assign idle_inc    = (idle_q == sle_pkg::IdleMax) ? idle_q : idle_q + 16'd1;

  // Item processing
  always_comb begin
    cur_len_d    = cur_len_q;
    idle_d       = idle_q;
    first_q_d    = first_q_q;
    wr_en        = 1'b0;
    wr_data      = in_if.payload.in_byte;
    new_ev_valid = 1'b0;
    new_ev.kind  = sle_pkg::EV_READ;
    new_ev.len   = cur_len_q;
    new_ev.quit  = 1'b0;
    if (in_fire) begin
      case (op)
        sle_pkg::OP_BYTE: begin
          idle_d = '0;
          if (in_if.payload.in_byte == sle_pkg::ChCr ||
              in_if.payload.in_byte == sle_pkg::ChLf) begin
            new_ev_valid = 1'b1;
            new_ev.kind  = sle_pkg::EV_LINE;
            new_ev.quit  = (cur_len_q == 8'd1) && first_q_q;
            cur_len_d    = '0;
          end else if (in_if.payload.in_byte == sle_pkg::ChBs) begin
            if (cur_len_q != '0) begin
              new_ev_valid = 1'b1;
              new_ev.kind  = sle_pkg::EV_ERASE;
              cur_len_d    = cur_len_q - 8'd1;
            end
          end else if (in_if.payload.in_byte != sle_pkg::ChEsc) begin
            wr_en = 1'b1;
            if (in_if.payload.in_byte == sle_pkg::ChTab) begin
              wr_data = sle_pkg::ChSpace;
            end
            if (cur_len_q == '0) begin
              first_q_d = (wr_data == sle_pkg::ChQ);
            end
            if (cur_len_q < LenLimit) begin
              cur_len_d = cur_len_q + 8'd1;
            end
          end
        end
        sle_pkg::OP_TICK: begin
          if (idle_inc > max_wait_q) begin
            new_ev_valid = 1'b1;
            new_ev.kind  = sle_pkg::EV_TIMEOUT;
            cur_len_d    = '0;
            idle_d       = '0;
          end else begin
            idle_d = idle_inc;
          end
        end
        sle_pkg::OP_READ: begin
          new_ev_valid = 1'b1;
          new_ev.kind  = sle_pkg::EV_READ;
        end
        default: begin
        end
      endcase
    end
  end

  // Line memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[cur_len_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && op == sle_pkg::OP_READ) begin
      rd_q <= store_mem[in_if.payload.read_index];
    end
  end

  // Result sequencer
  always_comb begin
    em_valid_d = em_valid_q;
    em_d       = em_q;
    em_byte_d  = em_byte_q;
    em_step_d  = em_step_q;
    if (ev_take) begin
      em_valid_d = 1'b1;
      em_d       = ev_q;
      em_byte_d  = rd_q;
      em_step_d  = sle_pkg::STEP_FIRST;
    end else if (em_done) begin
      em_valid_d = 1'b0;
    end else if (em_valid_q && out_if.ready) begin
      em_step_d = sle_pkg::step_e'(em_step_q + 2'd1);
    end
  end

  always_comb begin
    out_if.payload             = '0;
    out_if.payload.result_kind = sle_pkg::RK_ECHO;
    em_last                    = 1'b1;
    case (em_q.kind)
      sle_pkg::EV_LINE: begin
        if (em_step_q == sle_pkg::STEP_FIRST) begin
          out_if.payload.out_byte = sle_pkg::ChLf;
          em_last                 = 1'b0;
        end else begin
          out_if.payload.result_kind = sle_pkg::RK_DONE;
          out_if.payload.line_length = em_q.len;
          out_if.payload.quit        = em_q.quit;
        end
      end
      sle_pkg::EV_ERASE: begin
        case (em_step_q)
          sle_pkg::STEP_FIRST: begin
            out_if.payload.out_byte = sle_pkg::ChBs;
            em_last                 = 1'b0;
          end
          sle_pkg::STEP_SECOND: begin
            out_if.payload.out_byte = sle_pkg::ChSpace;
            em_last                 = 1'b0;
          end
          default: begin
            out_if.payload.out_byte = sle_pkg::ChBs;
          end
        endcase
      end
      sle_pkg::EV_TIMEOUT: begin
        out_if.payload.result_kind = sle_pkg::RK_TIMEOUT;
      end
      default: begin
        out_if.payload.result_kind = sle_pkg::RK_READ;
        out_if.payload.out_byte    = em_byte_q;
      end
    endcase
    out_if.payload.last = em_last;
  end

  assign out_if.valid = em_valid_q;
  assign ev_valid_d   = new_ev_valid || (ev_valid_q && !ev_take);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q  <= '0;
      idle_q     <= '0;
      first_q_q  <= 1'b0;
      ev_valid_q <= 1'b0;
      em_valid_q <= 1'b0;
      em_step_q  <= sle_pkg::STEP_FIRST;
    end else begin
      cur_len_q  <= cur_len_d;
      idle_q     <= idle_d;
      first_q_q  <= first_q_d;
      ev_valid_q <= ev_valid_d;
      em_valid_q <= em_valid_d;
      em_step_q  <= em_step_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (new_ev_valid) begin
      ev_q <= new_ev;
    end
    em_q      <= em_d;
    em_byte_q <= em_byte_d;
  end

endmodule
